[hdl/amd_pkg.sv]
// Shared widths, latencies and constants of the affine matrix decompose unit.
`timescale 1ns / 1ps
package amd_pkg;

    localparam int DATA_W       = 32;
    localparam int NUM_COL      = 3;
    localparam int COL_W        = 2;
    localparam int IN_W         = NUM_COL * 4 * DATA_W;
    localparam int ANGLE_W      = 25;
    localparam int OUT_FIELDS_W = 5 * DATA_W + ANGLE_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int USER_W       = COL_W + 1;

    localparam int SQ_W         = 2 * DATA_W;
    localparam int ROOT_STEPS   = SQ_W / 2;
    localparam int ROOT_W       = ROOT_STEPS + 1;
    localparam int SQRT_LAT     = ROOT_STEPS + 1;

    localparam int NORM_SHIFT   = 30;
    localparam int QUO_W        = NORM_SHIFT + 1;
    localparam int NUM_W        = DATA_W + NORM_SHIFT + 1;
    localparam int DIV_LAT      = QUO_W;

    localparam int CIN_W        = DATA_W + 2;
    localparam int CX_W         = CIN_W + 1;
    localparam int ZW           = ANGLE_W + 1;
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    localparam int LANE_LAT     = SQRT_LAT + DIV_LAT + 4;
    localparam int MERGE_LAT    = SQRT_LAT + CORDIC_LAT + 2;
    localparam int TOT_LAT      = LANE_LAT + MERGE_LAT;

    localparam logic [COL_W-1:0]      COL_LAST = COL_W'(NUM_COL - 1);
    localparam logic [DATA_W-1:0]     NORM_ONE = DATA_W'(1) << NORM_SHIFT;
    localparam logic signed [ZW-1:0]  ANG_90   = ZW'(5898240);
    localparam logic signed [ZW-1:0]  ANG_180  = ZW'(11796480);

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/affine_matrix_decompose_unit.sv]
// Top level: three column lanes, angle merge and a three-beat output stage.
//
//  channel | direction | tdata                         | tuser            | tlast
//  s_      | in        | c0_x..c2_z, t_x, t_y, t_z     | -                | -
//  m_      | out       | scale, norm_xyz, angle, pos   | column, zero_scl | last
//
// One matrix transfer yields three result transfers; a new matrix is taken
// every cycle while the pipeline moves, so the sustained rate is set by the
// three beats of the output stage. The path from input transfer to first result
// runs through the lane roots and dividers, the Y root and the CORDIC stages.
// Reset clears the valid line and the output stage. A stalled output freezes
// the whole pipeline once a further result is waiting at its end.
`timescale 1ns / 1ps
module affine_matrix_decompose_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z, t_x, t_y, t_z
    input  logic [amd_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // scale, norm_x, norm_y, norm_z, angle, position, zero pad
    output logic [amd_pkg::OUT_W-1:0]     m_tdata,
    // column, zero_scale
    output logic [amd_pkg::USER_W-1:0]    m_tuser,
    output logic                          m_tlast
);
    import amd_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]          scale;
        logic [2:0][DATA_W-1:0]     norm;
        logic                       zero;
    } lane_res_t;

    logic                                   adv, out_xfer, done, vld_last;
    logic [TOT_LAT-1:0]                     vld_reg, vld_next;
    logic                                   hold_reg, hold_next;
    logic [COL_W-1:0]                       beat_reg, beat_next;

    logic [NUM_COL-1:0][DATA_W-1:0]         pos_dly [0:TOT_LAT-1];
    lane_res_t [NUM_COL-1:0]                lane_res;
    lane_res_t [NUM_COL-1:0]                res_dly [0:MERGE_LAT-1];
    logic [NUM_COL-1:0][2:0][DATA_W-1:0]    lane_norm;
    logic [NUM_COL-1:0]                     lane_zero;
    logic [NUM_COL-1:0][ANGLE_W-1:0]        angle;

    lane_res_t [NUM_COL-1:0]                res_hold;
    logic [NUM_COL-1:0][DATA_W-1:0]         pos_hold;
    logic [NUM_COL-1:0][ANGLE_W-1:0]        ang_hold;

    assign vld_last = vld_reg[TOT_LAT-1];
    assign out_xfer = hold_reg && m_tready;
    assign done     = out_xfer && (beat_reg == COL_LAST);
    assign adv      = !vld_last || !hold_reg || done;
    assign s_tready = adv;

    for (genvar k = 0; k < NUM_COL; k++) begin : g_lane
        amd_lane u_lane (
            .aclk  (aclk),
            .en    (adv),
            .col   (s_tdata[k*3*DATA_W +: 3*DATA_W]),
            .scale (lane_res[k].scale),
            .norm  (lane_res[k].norm),
            .zero  (lane_res[k].zero)
        );
        assign lane_norm[k] = lane_res[k].norm;
        assign lane_zero[k] = lane_res[k].zero;
    end

    amd_merge u_merge (
        .aclk  (aclk),
        .en    (adv),
        .norm  (lane_norm),
        .zero  (lane_zero),
        .angle (angle)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            pos_dly[0] <= s_tdata[NUM_COL*3*DATA_W +: NUM_COL*DATA_W];
            for (int i = 1; i < TOT_LAT; i++)
                pos_dly[i] <= pos_dly[i-1];
            res_dly[0] <= lane_res;
            for (int i = 1; i < MERGE_LAT; i++)
                res_dly[i] <= res_dly[i-1];
            if (vld_last) begin
                res_hold <= res_dly[MERGE_LAT-1];
                pos_hold <= pos_dly[TOT_LAT-1];
                ang_hold <= angle;
            end
        end
    end

    always_comb begin
        vld_next  = vld_reg;
        hold_next = hold_reg;
        beat_next = beat_reg;
        if (adv)
            vld_next = {vld_reg[TOT_LAT-2:0], s_tvalid};
        if (adv && vld_last) begin
            hold_next = 1'b1;
            beat_next = '0;
        end else if (done) begin
            hold_next = 1'b0;
            beat_next = '0;
        end else if (out_xfer) begin
            beat_next = beat_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            hold_reg <= 1'b0;
            beat_reg <= '0;
        end else begin
            vld_reg  <= vld_next;
            hold_reg <= hold_next;
            beat_reg <= beat_next;
        end
    end

    assign m_tvalid = hold_reg;
    assign m_tdata  = {{(OUT_W - OUT_FIELDS_W){1'b0}},
                       pos_hold[beat_reg],
                       ang_hold[beat_reg],
                       res_hold[beat_reg].norm[2],
                       res_hold[beat_reg].norm[1],
                       res_hold[beat_reg].norm[0],
                       res_hold[beat_reg].scale};
    assign m_tuser  = {res_hold[beat_reg].zero, beat_reg};
    assign m_tlast  = (beat_reg == COL_LAST);

endmodule

[hdl/amd_isqrt.sv]
// Pipelined rounded integer square root, one root bit per stage.
`timescale 1ns / 1ps
module amd_isqrt (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [amd_pkg::SQ_W-1:0]    rad,
    output logic [amd_pkg::ROOT_W-1:0]  root
);
    import amd_pkg::*;

    logic [SQ_W+1:0]       rem_reg [0:ROOT_STEPS-1];
    logic [ROOT_STEPS-1:0] q_reg   [0:ROOT_STEPS-1];
    logic [ROOT_W-1:0]     root_reg;

    for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
        localparam int K = ROOT_STEPS - 1 - s;
        logic [SQ_W+1:0]       rem_in;
        logic [SQ_W+1:0]       trial;
        logic [ROOT_STEPS-1:0] q_in;
        if (s == 0) begin : g_first
            assign rem_in = {2'b00, rad};
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
        end
        assign trial = ({{(SQ_W + 2 - ROOT_STEPS){1'b0}}, q_in} << (K + 1))
                     + ((SQ_W + 2)'(1) << (2 * K));
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_in >= trial) begin
                    rem_reg[s] <= rem_in - trial;
                    q_reg[s]   <= q_in | (ROOT_STEPS'(1) << K);
                end else begin
                    rem_reg[s] <= rem_in;
                    q_reg[s]   <= q_in;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (rem_reg[ROOT_STEPS-1] > {{(SQ_W + 2 - ROOT_STEPS){1'b0}}, q_reg[ROOT_STEPS-1]})
                root_reg <= {1'b0, q_reg[ROOT_STEPS-1]} + ROOT_W'(1);
            else
                root_reg <= {1'b0, q_reg[ROOT_STEPS-1]};
        end
    end

    assign root = root_reg;

endmodule

[hdl/amd_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module amd_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [amd_pkg::NUM_W-1:0]   num,
    input  logic [amd_pkg::DATA_W-1:0]  den,
    output logic [amd_pkg::QUO_W-1:0]   quo
);
    import amd_pkg::*;

    logic [NUM_W-1:0]  rem_reg [0:QUO_W-1];
    logic [QUO_W-1:0]  q_reg   [0:QUO_W-1];
    logic [DATA_W-1:0] d_reg   [0:QUO_W-1];

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        localparam int J = QUO_W - 1 - s;
        logic [NUM_W-1:0]  rem_in;
        logic [NUM_W-1:0]  dsh;
        logic [QUO_W-1:0]  q_in;
        logic [DATA_W-1:0] d_in;
        if (s == 0) begin : g_first
            assign rem_in = num;
            assign q_in   = '0;
            assign d_in   = den;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign d_in   = d_reg[s-1];
        end
        assign dsh = {{(NUM_W - DATA_W){1'b0}}, d_in} << J;
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[s] <= d_in;
                if (rem_in >= dsh) begin
                    rem_reg[s] <= rem_in - dsh;
                    q_reg[s]   <= q_in | (QUO_W'(1) << J);
                end else begin
                    rem_reg[s] <= rem_in;
                    q_reg[s]   <= q_in;
                end
            end
        end
    end

    assign quo = q_reg[QUO_W-1];

endmodule

[hdl/amd_cordic.sv]
// Pipelined CORDIC atan2 in Q9.16 degrees with axis special cases and clamp.
`timescale 1ns / 1ps
module amd_cordic (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [amd_pkg::CIN_W-1:0]   cy,
    input  logic signed [amd_pkg::CIN_W-1:0]   cx,
    output logic [amd_pkg::ANGLE_W-1:0]        angle
);
    import amd_pkg::*;

    logic signed [CX_W-1:0] x_reg    [0:CORDIC_STEPS];
    logic signed [CX_W-1:0] y_reg    [0:CORDIC_STEPS];
    logic signed [ZW-1:0]   z_reg    [0:CORDIC_STEPS];
    logic                   spec_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0]   sval_reg [0:CORDIC_STEPS];
    logic [ANGLE_W-1:0]     angle_reg;

    logic signed [CX_W-1:0] x0, y0, ex, ey;
    logic signed [ZW-1:0]   z0, sval0, zc, zf;
    logic                   spec0;

    assign ex = CX_W'(cx);
    assign ey = CX_W'(cy);

    always_comb begin
        spec0 = 1'b0;
        sval0 = '0;
        if (cy == 0) begin
            spec0 = 1'b1;
            sval0 = (cx < 0) ? ANG_180 : '0;
        end else if (cx == 0) begin
            spec0 = 1'b1;
            sval0 = (cy > 0) ? ANG_90 : -ANG_90;
        end
        x0 = ex;
        y0 = ey;
        z0 = '0;
        if (cx < 0) begin
            if (cy > 0) begin
                x0 = ey;
                y0 = -ex;
                z0 = ANG_90;
            end else begin
                x0 = -ey;
                y0 = ex;
                z0 = -ANG_90;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x0;
            y_reg[0]    <= y0;
            z_reg[0]    <= z0;
            spec_reg[0] <= spec0;
            sval_reg[0] <= sval0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                spec_reg[i+1] <= spec_reg[i];
                sval_reg[i+1] <= sval_reg[i];
                if (!y_reg[i][CX_W-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q16(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q16(i);
                end
            end
        end
    end

    always_comb begin
        zc = z_reg[CORDIC_STEPS];
        if (zc > ANG_180)
            zc = ANG_180;
        else if (zc < -ANG_180)
            zc = -ANG_180;
        zf = spec_reg[CORDIC_STEPS] ? sval_reg[CORDIC_STEPS] : zc;
    end

    always_ff @(posedge aclk) begin
        if (en)
            angle_reg <= zf[ANGLE_W-1:0];
    end

    assign angle = angle_reg;

endmodule

[hdl/amd_lane.sv]
// One column lane: length by square root, then three normalizing divisions.
`timescale 1ns / 1ps
module amd_lane (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [2:0][amd_pkg::DATA_W-1:0]   col,
    output logic [amd_pkg::DATA_W-1:0]        scale,
    output logic [2:0][amd_pkg::DATA_W-1:0]   norm,
    output logic                              zero
);
    import amd_pkg::*;

    logic [2:0][DATA_W-1:0] mag;
    logic [2:0]             sgn;

    logic [2:0][SQ_W-1:0]   sq_reg;
    logic [2:0][DATA_W-1:0] mag_reg;
    logic [3:0]             flg_reg;
    logic [SQ_W-1:0]        sum_reg;

    logic [2:0][DATA_W-1:0] mag_dly [0:SQRT_LAT];
    logic [3:0]             flg_dly [0:SQRT_LAT];
    logic [ROOT_W-1:0]      root;
    logic [DATA_W-1:0]      sat;

    logic [2:0][NUM_W-1:0]  num_reg;
    logic [DATA_W-1:0]      den_dly [0:DIV_LAT];
    logic [3:0]             flg_q   [0:DIV_LAT];
    logic [2:0][QUO_W-1:0]  quo;

    logic [DATA_W-1:0]      scale_reg;
    logic [2:0][DATA_W-1:0] norm_reg;
    logic                   zero_reg;

    for (genvar j = 0; j < 3; j++) begin : g_mag
        assign sgn[j] = col[j][DATA_W-1];
        assign mag[j] = sgn[j] ? (~col[j] + DATA_W'(1)) : col[j];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++)
                sq_reg[j] <= SQ_W'(mag[j]) * SQ_W'(mag[j]);
            mag_reg    <= mag;
            flg_reg    <= {(col == '0), sgn};
            sum_reg    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            mag_dly[0] <= mag_reg;
            flg_dly[0] <= flg_reg;
            for (int i = 1; i <= SQRT_LAT; i++) begin
                mag_dly[i] <= mag_dly[i-1];
                flg_dly[i] <= flg_dly[i-1];
            end
        end
    end

    amd_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (sum_reg),
        .root (root)
    );

    assign sat = root[ROOT_W-1] ? '1 : root[DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++)
                num_reg[j] <= {1'b0, mag_dly[SQRT_LAT][j], {NORM_SHIFT{1'b0}}}
                            + {{(NUM_W - DATA_W + 1){1'b0}}, sat[DATA_W-1:1]};
            den_dly[0] <= sat;
            flg_q[0]   <= flg_dly[SQRT_LAT];
            for (int i = 1; i <= DIV_LAT; i++) begin
                den_dly[i] <= den_dly[i-1];
                flg_q[i]   <= flg_q[i-1];
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_div
        amd_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num_reg[j]),
            .den  (den_dly[0]),
            .quo  (quo[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scale_reg <= den_dly[DIV_LAT];
            zero_reg  <= flg_q[DIV_LAT][3];
            for (int j = 0; j < 3; j++) begin
                if (flg_q[DIV_LAT][3])
                    norm_reg[j] <= '0;
                else if (flg_q[DIV_LAT][j])
                    norm_reg[j] <= ~{1'b0, quo[j]} + DATA_W'(1);
                else
                    norm_reg[j] <= {1'b0, quo[j]};
            end
        end
    end

    assign scale = scale_reg;
    assign norm  = norm_reg;
    assign zero  = zero_reg;

endmodule

[hdl/amd_merge.sv]
// Merge of the three lanes: unit axes, Y denominator root and three CORDICs.
`timescale 1ns / 1ps
module amd_merge (
    input  logic                                              aclk,
    input  logic                                              en,
    input  logic [amd_pkg::NUM_COL-1:0][2:0][amd_pkg::DATA_W-1:0] norm,
    input  logic [amd_pkg::NUM_COL-1:0]                       zero,
    output logic [amd_pkg::NUM_COL-1:0][amd_pkg::ANGLE_W-1:0] angle
);
    import amd_pkg::*;

    localparam int U0X = 0;
    localparam int U0Y = 1;
    localparam int U0Z = 2;
    localparam int U1Z = 3;
    localparam int U2Z = 4;

    logic [4:0][DATA_W-1:0] u;
    logic [DATA_W-1:0]      ma, mb;
    logic [4:0][DATA_W-1:0] u_reg;
    logic [SQ_W-1:0]        sqa_reg, sqb_reg, rad_reg;
    logic [4:0][DATA_W-1:0] u_dly [0:SQRT_LAT];
    logic [ROOT_W-1:0]      root;
    logic [CIN_W-1:0]       ext0z;

    assign u[U0X] = zero[0] ? NORM_ONE : norm[0][0];
    assign u[U0Y] = zero[0] ? '0 : norm[0][1];
    assign u[U0Z] = zero[0] ? '0 : norm[0][2];
    assign u[U1Z] = zero[1] ? '0 : norm[1][2];
    assign u[U2Z] = zero[2] ? NORM_ONE : norm[2][2];

    assign ma = u[U1Z][DATA_W-1] ? (~u[U1Z] + DATA_W'(1)) : u[U1Z];
    assign mb = u[U2Z][DATA_W-1] ? (~u[U2Z] + DATA_W'(1)) : u[U2Z];

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg    <= u;
            sqa_reg  <= SQ_W'(ma) * SQ_W'(ma);
            sqb_reg  <= SQ_W'(mb) * SQ_W'(mb);
            rad_reg  <= sqa_reg + sqb_reg;
            u_dly[0] <= u_reg;
            for (int i = 1; i <= SQRT_LAT; i++)
                u_dly[i] <= u_dly[i-1];
        end
    end

    amd_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (rad_reg),
        .root (root)
    );

    assign ext0z = {{(CIN_W - DATA_W){u_dly[SQRT_LAT][U0Z][DATA_W-1]}}, u_dly[SQRT_LAT][U0Z]};

    amd_cordic u_ang_x (
        .aclk  (aclk),
        .en    (en),
        .cy    (signed'({{(CIN_W - DATA_W){u_dly[SQRT_LAT][U1Z][DATA_W-1]}},
                         u_dly[SQRT_LAT][U1Z]})),
        .cx    (signed'({{(CIN_W - DATA_W){u_dly[SQRT_LAT][U2Z][DATA_W-1]}},
                         u_dly[SQRT_LAT][U2Z]})),
        .angle (angle[0])
    );

    amd_cordic u_ang_y (
        .aclk  (aclk),
        .en    (en),
        .cy    (signed'(~ext0z + CIN_W'(1))),
        .cx    (signed'({{(CIN_W - ROOT_W){1'b0}}, root})),
        .angle (angle[1])
    );

    amd_cordic u_ang_z (
        .aclk  (aclk),
        .en    (en),
        .cy    (signed'({{(CIN_W - DATA_W){u_dly[SQRT_LAT][U0Y][DATA_W-1]}},
                         u_dly[SQRT_LAT][U0Y]})),
        .cx    (signed'({{(CIN_W - DATA_W){u_dly[SQRT_LAT][U0X][DATA_W-1]}},
                         u_dly[SQRT_LAT][U0X]})),
        .angle (angle[2])
    );

endmodule
